FILE: hw/rtl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg
// Shared types and constants of the multichannel biquad filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package bqf_pkg;

   // Default sizing of the core
   localparam int NUM_CHANNELS_DEF   = 8;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 28;

   // Fixed field widths
   localparam int COEF_BITS      = 32;
   localparam int CHAN_BITS      = 3;
   localparam int CSR_INDEX_BITS = 3;

   // Coefficient register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_B0 = 3'd0,
      REG_B1 = 3'd1,
      REG_B2 = 3'd2,
      REG_A1 = 3'd3,
      REG_A2 = 3'd4
   } csr_reg_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   // Full coefficient set, Q3.28, already divided by a0
   typedef struct packed {
      coef_type b0;
      coef_type b1;
      coef_type b2;
      coef_type a1;
      coef_type a2;
   } coef_set_type;

   // Stage load strobes from the pipeline control to the datapath
   typedef struct packed {
      logic s2_load;
      logic s3_load;
   } dp_ctrl_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bqf_state_mem.sv
// ----------------------------------------------------------------------------
// bqf_state_mem
// Per-channel delay state: one word {x1, x2, y1, y2} per channel, registered
// read port, one write port. Entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_state_mem
   import bqf_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   localparam int ADDR_BITS   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
   localparam int WORD_BITS   = 4 * SAMPLE_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WORD_BITS-1:0] rd_word,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_word
);

   logic [WORD_BITS-1:0]    mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] written_ff;
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic                    rd_written_ff;

   // Storage array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_word;
      end
   end

   // Per-entry written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff    <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_word = rd_written_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/bqf_datapath.sv
// ----------------------------------------------------------------------------
// bqf_datapath
// Biquad arithmetic: five parallel products (registered), wide sum with the
// rounding bias (registered), then shift, saturate and writeback word.
// ----------------------------------------------------------------------------
`default_nettype none

module bqf_datapath
   import bqf_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   localparam int WORD_BITS     = 4 * SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire dp_ctrl_type                   ctrl,
   input  wire coef_set_type                  coefs,
   input  wire logic signed [SAMPLE_BITS-1:0] x,
   input  wire logic        [WORD_BITS-1:0]   state_word,
   output logic signed      [SAMPLE_BITS-1:0] y,
   output logic             [WORD_BITS-1:0]   wb_word
);

   localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS  = PROD_BITS + 3;
   localparam logic signed [ACC_BITS-1:0] RoundBias = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2;
   logic signed [PROD_BITS-1:0]   p0_in, p1_in, p2_in, p3_in, p4_in;
   logic signed [PROD_BITS-1:0]   p0_ff, p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [SAMPLE_BITS-1:0] s2_x_ff, s2_x1_ff, s2_y1_ff;
   logic signed [ACC_BITS-1:0]    acc_in, acc_ff;
   logic signed [SAMPLE_BITS-1:0] s3_x_ff, s3_x1_ff, s3_y1_ff;
   logic signed [ACC_BITS-1:0]    quot;
   logic                          ovf;

   // Unpack delay state
   assign x1 = $signed(state_word[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);
   assign x2 = $signed(state_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
   assign y1 = $signed(state_word[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign y2 = $signed(state_word[SAMPLE_BITS-1:0]);

   // Products, operands sign extended to full product width
   assign p0_in = PROD_BITS'(coefs.b0) * PROD_BITS'(x);
   assign p1_in = PROD_BITS'(coefs.b1) * PROD_BITS'(x1);
   assign p2_in = PROD_BITS'(coefs.b2) * PROD_BITS'(x2);
   assign p3_in = PROD_BITS'(coefs.a1) * PROD_BITS'(y1);
   assign p4_in = PROD_BITS'(coefs.a2) * PROD_BITS'(y2);

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         s2_x_ff  <= x;
         s2_x1_ff <= x1;
         s2_y1_ff <= y1;
      end
   end

   // Exact sum; feedback taps subtracted, rounding bias folded in
   assign acc_in = ACC_BITS'(p0_ff) + ACC_BITS'(p1_ff) + ACC_BITS'(p2_ff)
                 - ACC_BITS'(p3_ff) - ACC_BITS'(p4_ff) + RoundBias;

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         acc_ff   <= acc_in;
         s3_x_ff  <= s2_x_ff;
         s3_x1_ff <= s2_x1_ff;
         s3_y1_ff <= s2_y1_ff;
      end
   end

   // Floor shift, then clamp when bits above the sample sign disagree
   assign quot = acc_ff >>> COEF_FRAC_BITS;
   assign ovf  = !((&quot[ACC_BITS-1:SAMPLE_BITS-1]) || !(|quot[ACC_BITS-1:SAMPLE_BITS-1]));
   assign y    = ovf ? (acc_ff[ACC_BITS-1] ? SampleMin : SampleMax)
                     : quot[SAMPLE_BITS-1:0];

   // Shifted delay line for writeback
   assign wb_word = {s3_x_ff, s3_x1_ff, y, s3_y1_ff};

endmodule

`default_nettype wire

FILE: hw/rtl/multichannel_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_core
// Direct form I biquad over up to NUM_CHANNELS interleaved channels.
// ----------------------------------------------------------------------------
// Takes one request per clock as long as the output side is not holding the
// pipeline and a request's channel differs from the channels of the requests
// still in the three pipeline stages; results appear in request order. The
// channel state lives in a memory that is read when a request is accepted and
// written back when its result enters the output register, so a request for
// a channel that is still among the three in flight is held until that
// writeback. The pipeline fills its bubbles and keeps accepting while a
// result waits in the output register, until its stages are full. The user
// must write coefficients through the csr port only while the core is idle;
// the core does not enforce this. A channel index at or above NUM_CHANNELS
// returns zero and leaves all state untouched.
`default_nettype none

module multichannel_biquad_filter_core
   import bqf_pkg::*;
#(
   parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic        [CHAN_BITS-1:0]   req_chan_in,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed      [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic             [CHAN_BITS-1:0]   rsp_chan_out,
   // coefficient registers
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [COEF_BITS-1:0]          csr_wdata
);

   localparam int ADDR_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int WORD_BITS = 4 * SAMPLE_BITS;
   localparam coef_type B0Reset = COEF_BITS'(1) << COEF_FRAC_BITS;

   coef_set_type coefs_ff;

   logic                          accept;
   logic                          hazard;
   logic                          req_live;
   logic                          s1_open, s2_open, s3_open, rsp_open;
   logic                          s1_move, s2_move, s3_move;

   logic                          s1_v_ff, s2_v_ff, s3_v_ff;
   logic                          s1_live_ff, s2_live_ff, s3_live_ff;
   logic [CHAN_BITS-1:0]          s1_chan_ff, s2_chan_ff, s3_chan_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [CHAN_BITS-1:0]          rsp_chan_ff;

   logic [WORD_BITS-1:0]          state_word;
   logic [WORD_BITS-1:0]          wb_word;
   logic signed [SAMPLE_BITS-1:0] y;
   dp_ctrl_type                   dp_ctrl;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= B0Reset;
         coefs_ff.b1 <= '0;
         coefs_ff.b2 <= '0;
         coefs_ff.a1 <= '0;
         coefs_ff.a2 <= '0;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_B0:  coefs_ff.b0 <= $signed(csr_wdata);
            REG_B1:  coefs_ff.b1 <= $signed(csr_wdata);
            REG_B2:  coefs_ff.b2 <= $signed(csr_wdata);
            REG_A1:  coefs_ff.a1 <= $signed(csr_wdata);
            REG_A2:  coefs_ff.a2 <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Pipeline flow: a stage may take new data when empty or draining
   assign rsp_open = !rsp_valid_ff || rsp_ready;
   assign s3_move  = s3_v_ff && rsp_open;
   assign s3_open  = !s3_v_ff || rsp_open;
   assign s2_move  = s2_v_ff && s3_open;
   assign s2_open  = !s2_v_ff || s3_open;
   assign s1_move  = s1_v_ff && s2_open;
   assign s1_open  = !s1_v_ff || s2_open;

   // Hold a request whose channel state is not yet written back
   assign hazard = (s1_v_ff && (s1_chan_ff == req_chan_in))
                || (s2_v_ff && (s2_chan_ff == req_chan_in))
                || (s3_v_ff && (s3_chan_ff == req_chan_in));

   assign req_ready = s1_open && !hazard && !reset;
   assign accept    = req_valid && req_ready;
   assign req_live  = 32'(req_chan_in) < 32'(NUM_CHANNELS);

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_move) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_v_ff <= 1'b1;
         end else if (s2_move) begin
            s2_v_ff <= 1'b0;
         end
         if (s2_move) begin
            s3_v_ff <= 1'b1;
         end else if (s3_move) begin
            s3_v_ff <= 1'b0;
         end
         if (s3_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Stage side-band: channel, in-range flag and the input sample of stage 1
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_chan_ff <= req_chan_in;
         s1_live_ff <= req_live;
         s1_x_ff    <= req_sample_in;
      end
      if (s1_move) begin
         s2_chan_ff <= s1_chan_ff;
         s2_live_ff <= s1_live_ff;
      end
      if (s2_move) begin
         s3_chan_ff <= s2_chan_ff;
         s3_live_ff <= s2_live_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s3_move) begin
         rsp_sample_ff <= s3_live_ff ? y : '0;
         rsp_chan_ff   <= s3_chan_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_chan_out   = rsp_chan_ff;

   assign dp_ctrl.s2_load = s1_move;
   assign dp_ctrl.s3_load = s2_move;

   bqf_state_mem #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(req_chan_in)),
      .rd_word (state_word),
      .wr_en   (s3_move && s3_live_ff),
      .wr_addr (ADDR_BITS'(s3_chan_ff)),
      .wr_word (wb_word)
   );

   bqf_datapath #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .ctrl       (dp_ctrl),
      .coefs      (coefs_ff),
      .x          (s1_x_ff),
      .state_word (state_word),
      .y          (y),
      .wb_word    (wb_word)
   );

endmodule

`default_nettype wire

FILE: verif/biquad_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_tb_pkg
// Scoreboard for the multichannel biquad filter core. It keeps its own
// coefficients and per-channel delay lines, predicts the filtered sample of
// every accepted request and checks each response against the oldest one.
// ----------------------------------------------------------------------------

package biquad_tb_pkg;

   import bqf_pkg::*;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
   typedef logic        [CHAN_BITS-1:0]       chan_t;

   // One filtered sample as the core should return it
   typedef struct {
      sample_t sample;
      chan_t   chan;
   } filtered_sample_t;

   localparam longint ROUND_HALF = longint'(1) << (COEF_FRAC_BITS_DEF - 1);
   localparam longint RAIL_HI    = (longint'(1) << (SAMPLE_BITS_DEF - 1)) - 1;
   localparam longint RAIL_LO    = -RAIL_HI - 1;

   class biquad_scoreboard;

      coef_set_type     coefs;
      sample_t          x_hist1 [NUM_CHANNELS_DEF];
      sample_t          x_hist2 [NUM_CHANNELS_DEF];
      sample_t          y_hist1 [NUM_CHANNELS_DEF];
      sample_t          y_hist2 [NUM_CHANNELS_DEF];
      filtered_sample_t expected_outputs [$];
      int               error_count;

      function new();
         coefs       = '{b0: coef_type'(32'sh1000_0000), default: '0};
         error_count = 0;
         for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            x_hist1[i] = '0;
            x_hist2[i] = '0;
            y_hist1[i] = '0;
            y_hist2[i] = '0;
         end
      endfunction

      // Writes outside the coefficient map are dropped
      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [COEF_BITS-1:0] data);
         case (csr_reg_type'(index))
            REG_B0:  coefs.b0 = data;
            REG_B1:  coefs.b1 = data;
            REG_B2:  coefs.b2 = data;
            REG_A1:  coefs.a1 = data;
            REG_A2:  coefs.a2 = data;
            default: ;
         endcase
      endfunction

      // Direct form I step: exact sum, round half up, clamp, update delays
      function filtered_sample_t filter_step(sample_t x, chan_t ch);
         filtered_sample_t r;
         longint acc;
         longint rounded;
         r.chan   = ch;
         r.sample = '0;
         if (int'(ch) >= NUM_CHANNELS_DEF)
            return r;
         acc = longint'(coefs.b0) * longint'(x)
             + longint'(coefs.b1) * longint'(x_hist1[ch])
             + longint'(coefs.b2) * longint'(x_hist2[ch])
             - longint'(coefs.a1) * longint'(y_hist1[ch])
             - longint'(coefs.a2) * longint'(y_hist2[ch]);
         rounded = (acc + ROUND_HALF) >>> COEF_FRAC_BITS_DEF;
         if (rounded > RAIL_HI)
            rounded = RAIL_HI;
         else if (rounded < RAIL_LO)
            rounded = RAIL_LO;
         r.sample    = sample_t'(rounded);
         x_hist2[ch] = x_hist1[ch];
         x_hist1[ch] = x;
         y_hist2[ch] = y_hist1[ch];
         y_hist1[ch] = r.sample;
         return r;
      endfunction

      function void note_request(sample_t x, chan_t ch);
         expected_outputs.push_back(filter_step(x, ch));
      endfunction

      function void check_response(sample_t got_sample, chan_t got_chan);
         filtered_sample_t want;
         if (expected_outputs.size() == 0) begin
            $display("%0t: response with no request pending: sample %0d channel %0d",
                     $time, got_sample, got_chan);
            error_count++;
            return;
         end
         want = expected_outputs.pop_front();
         if (got_sample !== want.sample) begin
            $display("%0t: sample_out mismatch: expected %0d actual %0d (channel %0d)",
                     $time, want.sample, got_sample, want.chan);
            error_count++;
         end
         if (got_chan !== want.chan) begin
            $display("%0t: chan_out mismatch: expected %0d actual %0d",
                     $time, want.chan, got_chan);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction

   endclass

endpackage

FILE: verif/multichannel_biquad_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_core_tb
// Self-checking bench: directed extremes, rounding ties and saturation cases,
// then random phases with fresh coefficient sets, random idling on both
// channels, a long response hold-off and drain pauses.
// ----------------------------------------------------------------------------

module multichannel_biquad_filter_core_tb;

   import bqf_pkg::*;
   import biquad_tb_pkg::*;

   localparam int NUM_PHASES       = 10;
   localparam int PHASE_REQUESTS   = 125;
   localparam int HOLD_PHASE       = 2;
   localparam int HOLD_CYCLES      = 200;
   localparam int UNMAPPED_PHASE   = 5;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 16;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LAST_CSR_INDEX   = (1 << CSR_INDEX_BITS) - 1;

   localparam coef_type COEF_ONE  = 32'sh1000_0000;
   localparam coef_type COEF_HALF = 32'sh0800_0000;
   localparam coef_type COEF_MAX  = 32'sh7FFF_FFFF;
   localparam coef_type COEF_MIN  = 32'sh8000_0000;
   localparam sample_t  SAMPLE_MAX = 24'sh7F_FFFF;
   localparam sample_t  SAMPLE_MIN = 24'sh80_0000;

   typedef enum int {COEF_FULL, COEF_UNITY, COEF_EXTREME} coef_style_t;

   logic                      clock;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_ready;
   sample_t                   req_sample_in  = '0;
   chan_t                     req_chan_in    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready      = 1'b0;
   sample_t                   rsp_sample_out;
   chan_t                     rsp_chan_out;
   logic                      csr_we         = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [COEF_BITS-1:0]      csr_wdata      = '0;

   biquad_scoreboard sb = new();

   bit rsp_idles       = 1'b1;
   int rsp_hold_cycles = 0;
   int quiet_cycles    = 0;

   multichannel_biquad_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .req_chan_in    (req_chan_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_chan_out   (rsp_chan_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Track every handshake and register write at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_request(req_sample_in, req_chan_in);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_sample_out, rsp_chan_out);
      end
   end

   // Watchdog: too long without any request, response or register write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side: random or no idling, plus one long hold-off on demand
   initial begin : response_sink
      int gap;
      forever begin
         if (rsp_hold_cycles > 0) begin
            repeat (rsp_hold_cycles) @(negedge clock) rsp_ready <= 1'b0;
            rsp_hold_cycles = 0;
         end
         gap = rsp_idles ? $urandom_range(0, 5) : 0;
         repeat (gap) @(negedge clock) rsp_ready <= 1'b0;
         @(negedge clock) rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Offer one request after an idle gap and hold it until accepted
   task automatic send_request(sample_t sample, chan_t chan, int gap);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= sample;
      req_chan_in   <= chan;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every response is back
   task automatic wait_idle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(logic [CSR_INDEX_BITS-1:0] index, logic [COEF_BITS-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
   endtask

   task automatic end_csr();
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic write_coefs(coef_set_type cs);
      wait_idle();
      put_csr(REG_B0, cs.b0);
      put_csr(REG_B1, cs.b1);
      put_csr(REG_B2, cs.b2);
      put_csr(REG_A1, cs.a1);
      put_csr(REG_A2, cs.a2);
      end_csr();
   endtask

   // Indexes past the map must not touch any coefficient
   task automatic write_unmapped();
      wait_idle();
      for (int i = int'(REG_A2) + 1; i <= LAST_CSR_INDEX; i++)
         put_csr(CSR_INDEX_BITS'(i), $urandom);
      end_csr();
   endtask

   function automatic coef_type draw_coef(coef_style_t style);
      case (style)
         COEF_UNITY:   return coef_type'($urandom_range(0, 32'h2000_0000)) - COEF_ONE;
         COEF_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return COEF_MIN;
               1:       return COEF_MAX;
               2:       return '0;
               3:       return COEF_ONE;
               default: return -COEF_ONE;
            endcase
         end
         default:      return coef_type'($urandom);
      endcase
   endfunction

   function automatic sample_t draw_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               3:       return -1;
               default: return 1;
            endcase
         end
         1, 2, 3: return sample_t'($urandom_range(0, 2048)) - 1024;
         default: return sample_t'($urandom);
      endcase
   endfunction

   task automatic run_directed();
      coef_set_type cs;
      // Reset coefficients pass samples through
      send_request(SAMPLE_MAX, 0, 0);
      send_request(SAMPLE_MIN, 1, 0);
      send_request(0, 2, 1);
      send_request(-1, 3, 0);
      send_request(1, 4, 2);
      send_request(24'sd12345, 7, 0);
      // Largest gain clips at both rails
      cs = '{b0: COEF_MAX, default: '0};
      write_coefs(cs);
      send_request(SAMPLE_MAX, 5, 0);
      send_request(SAMPLE_MIN, 6, 0);
      send_request(1, 0, 0);
      // Every tap at an extreme, one channel back to back
      cs = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MAX, a2: COEF_MAX};
      write_coefs(cs);
      repeat (3) send_request(SAMPLE_MIN, 2, 0);
      send_request(SAMPLE_MAX, 2, 0);
      // Half gain: exact halves round toward plus infinity
      cs = '{b0: COEF_HALF, default: '0};
      write_coefs(cs);
      write_unmapped();
      send_request(1, 3, 0);
      send_request(-1, 4, 0);
      send_request(3, 5, 0);
      send_request(-3, 5, 0);
      // Strong feedback from one impulse runs into the rails
      cs = '{b0: COEF_ONE, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MIN, a2: COEF_MAX};
      write_coefs(cs);
      send_request(1, 6, 0);
      repeat (3) send_request(0, 6, 1);
   endtask

   task automatic run_random_phase(int phase);
      coef_set_type cs;
      coef_style_t  style;
      bit           req_idles;
      bit           hazard;
      bit           flood;
      int           gap;
      chan_t        chan;
      style = (phase == NUM_PHASES - 1) ? COEF_EXTREME : coef_style_t'(phase % 3);
      cs.b0 = draw_coef(style);
      cs.b1 = draw_coef(style);
      cs.b2 = draw_coef(style);
      cs.a1 = draw_coef(style);
      cs.a2 = draw_coef(style);
      write_coefs(cs);
      if (phase == UNMAPPED_PHASE)
         write_unmapped();
      req_idles = (phase % 4 != 0);
      rsp_idles = (phase % 3 != 1);
      // Few channels in some phases to keep hitting same-channel hazards
      hazard    = (phase % 5 == 3);
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
         // Sender pauses mid-phase until everything has drained
         if (i == PHASE_REQUESTS / 2)
            wait_idle();
         // Long response hold-off while requests keep coming back to back
         if (phase == HOLD_PHASE && i == 10)
            rsp_hold_cycles = HOLD_CYCLES;
         flood = (phase == HOLD_PHASE) && (i >= 10) && (i < 60);
         gap   = (req_idles && !flood) ? $urandom_range(0, 5) : 0;
         chan  = hazard ? chan_t'($urandom_range(0, 1)) : chan_t'($urandom_range(0, 7));
         send_request(draw_sample(), chan, gap);
      end
   endtask

   // Main sequence
   initial begin : stimulus
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      run_directed();
      for (int p = 0; p < NUM_PHASES; p++)
         run_random_phase(p);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bqf_pkg.sv
hw/rtl/bqf_state_mem.sv
hw/rtl/bqf_datapath.sv
hw/rtl/multichannel_biquad_filter_core.sv
verif/biquad_tb_pkg.sv
verif/multichannel_biquad_filter_core_tb.sv
